// ----- rtl/core/psmq_pkg.sv -----
// Shared types and constants for the mouse packet queue.
package psmq_pkg;

  localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
  localparam logic [7:0] HDR_OVF_MASK   = 8'hC0;
  localparam logic [7:0] HDR_BTN_MASK   = 8'h07;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = 2;
  localparam int CMD_CNT_W      = 3;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } mouse_report_t;

  typedef struct packed {
    cmd_kind_t     kind;
    mouse_report_t ev;
  } cmd_t;

endpackage

// ----- rtl/core/psmq_front.sv -----
// Packet assembler: takes controller bytes and reads, issues push/pop commands.
module psmq_front import psmq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_fire,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic       from_aux,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_r, x_nxt;
  logic       byte_fire;

  assign byte_fire = item_fire && (opcode == OP_BYTE) && from_aux;

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    x_nxt      = x_r;
    cmd_valid  = 1'b0;
    cmd.kind   = CMD_POP;
    cmd.ev.buttons = header_r[2:0] & HDR_BTN_MASK[2:0];
    cmd.ev.dx      = x_r;
    cmd.ev.dy      = data_byte;
    if (item_fire && (opcode == OP_READ)) begin
      cmd_valid = 1'b1;
    end
    if (byte_fire) begin
      unique case (phase_r)
        PH_X: begin
          x_nxt     = data_byte;
          phase_nxt = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_HEAD;
          // drop packets with either overflow bit set
          if ((header_r & HDR_OVF_MASK) == 8'h00) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_PUSH;
          end
        end
        default: begin
          header_nxt = data_byte;
          phase_nxt  = ((data_byte & HDR_ALWAYS_ONE) != 8'h00) ? PH_X : PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      header_r <= 8'h00;
      x_r      <= 8'h00;
    end else begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      x_r      <= x_nxt;
    end
  end

endmodule

// ----- rtl/core/psmq_cmd_fifo.sv -----
// Short command queue between the assembler and the event ring.
module psmq_cmd_fifo import psmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_data
);

  cmd_t                 slot_r [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count_r == CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/psmq_back.sv -----
// Event ring: stores good packets, serves reads through a registered output.
module psmq_back import psmq_pkg::*; #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_got,
  output logic [23:0] out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  mouse_report_t ring_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_idx_r;
  logic [AW-1:0] rd_idx_r;
  logic [AW-1:0] wr_next;
  logic [AW-1:0] rd_next;
  mouse_report_t rd_q_r;
  logic          s1_valid_r;
  logic          s1_hit_r;
  logic          out_valid_r;
  logic          out_got_r;
  mouse_report_t out_ev_r;
  logic          s1_adv;
  logic          do_write;
  logic          do_read;
  logic          rd_hit;

  assign wr_next = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_next = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
  assign rd_hit  = (rd_idx_r != wr_idx_r);

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ready);
  assign cmd_pop = cmd_valid && ((cmd.kind == CMD_PUSH) || !s1_valid_r || s1_adv);
  assign do_write = cmd_pop && (cmd.kind == CMD_PUSH) && (wr_next != rd_idx_r);
  assign do_read  = cmd_pop && (cmd.kind == CMD_POP);

  always_ff @(posedge clk) begin
    if (do_write) begin
      ring_r[wr_idx_r] <= cmd.ev;
    end
    if (do_read && rd_hit) begin
      rd_q_r <= ring_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      s1_valid_r  <= 1'b0;
      s1_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_got_r   <= 1'b0;
    end else begin
      if (do_write) begin
        wr_idx_r <= wr_next;
      end
      if (do_read) begin
        s1_valid_r <= 1'b1;
        s1_hit_r   <= rd_hit;
        if (rd_hit) begin
          rd_idx_r <= rd_next;
        end
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        out_got_r   <= s1_hit_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev_r <= s1_hit_r ? rd_q_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_got   = out_got_r;
  assign out_data  = {5'b0, out_ev_r.dy, out_ev_r.dx, out_ev_r.buttons};

endmodule

// ----- rtl/core/ps2_mouse_packet_queue_top.sv -----
// Top level of the mouse packet queue: assembler, command queue and event ring.
//
//   channel  dir  tdata                          tuser
//   in_      in   [7:0] data_byte                [0] opcode, [1] from_aux
//   out_     out  [2:0] buttons, [10:3] dx,      [0] got_event
//                 [18:11] dy, [23:19] zero
//
// One item per cycle is taken while in_tready is high; each aux byte updates
// the packet phase and each read or good packet becomes one command. A read
// result passes the command queue, the ring read register and the output
// register in that order. Reset clears phase, header, x, queue pointers and
// count, ring indices and valid flags; the ring holds no reset values and
// needs no clearing pass. A stall on out_tready fills the output register,
// the read stage and the four-entry command queue, then drops in_tready.
module ps2_mouse_packet_queue_top import psmq_pkg::*; #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] opcode, [1] from_aux
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] buttons, [10:3] dx, [18:11] dy, rest zero
  output logic [0:0]  out_tuser   // [0] got_event
);

  logic in_fire;
  logic front_cmd_valid;
  cmd_t front_cmd;
  logic fifo_full;
  logic head_valid;
  cmd_t head_cmd;
  logic head_pop;
  logic back_got;

  // hold input while the command queue has no room
  assign in_tready = !fifo_full;
  assign in_fire   = in_tvalid && in_tready;

  psmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .opcode    (in_tuser[0]),
    .data_byte (in_tdata),
    .from_aux  (in_tuser[1]),
    .cmd_valid (front_cmd_valid),
    .cmd       (front_cmd)
  );

  psmq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_cmd_valid),
    .push_data  (front_cmd),
    .pop        (head_pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_data  (head_cmd)
  );

  psmq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_got   (back_got),
    .out_data  (out_tdata)
  );

  assign out_tuser[0] = back_got;

  // a command is never offered to a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    front_cmd_valid |-> !fifo_full)
    else $error("command pushed into full queue");

  // an empty read carries an all-zero payload
  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 24'h0))
    else $error("empty read with non-zero payload");

  // nothing is offered in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered straight after reset");

endmodule
